@@ hw/rtl/time_array_increment_unit_defines.svh @@
// assertion macros used by the checker module
`ifndef TIME_ARRAY_INCREMENT_UNIT_DEFINES_SVH
`define TIME_ARRAY_INCREMENT_UNIT_DEFINES_SVH

// checked on every rising edge out of reset
`define TAI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising edge, reset included
`define TAI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/tai_pkg.sv @@
// types, constants and constant-divide helpers for the time stamp increment pipeline
package tai_pkg;

   typedef logic [2:0] unit_idx_type;

   localparam unit_idx_type UNIT_CENTI = 3'd0;
   localparam unit_idx_type UNIT_SEC   = 3'd1;
   localparam unit_idx_type UNIT_MIN   = 3'd2;
   localparam unit_idx_type UNIT_HOUR  = 3'd3;
   localparam unit_idx_type UNIT_DAY   = 3'd4;
   localparam int           UNIT_COUNT = 5;

   localparam logic [2:0] RES_CENTI = 3'd1;
   localparam logic [2:0] RES_DAY   = 3'd5;

   // one pipeline stage register: the stamp plus the state of the ripple
   typedef struct packed {
      logic [6:0]  centiseconds;
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [4:0]  hours;
      logic [8:0]  day_of_year;
      logic [15:0] year;
      logic [15:0] carry;
      logic [16:0] sum;
      logic [15:0] quot;
      logic        below;
      unit_idx_type start;
      logic        live;
   } tai_item_type;

   function automatic logic [8:0] radix(unit_idx_type idx, logic leap);
      logic [8:0] r;
      unique case (idx)
         UNIT_CENTI: r = 9'd100;
         UNIT_SEC:   r = 9'd60;
         UNIT_MIN:   r = 9'd60;
         UNIT_HOUR:  r = 9'd24;
         default:    r = leap ? 9'd367 : 9'd366;
      endcase
      return r;
   endfunction

   // ceil(2^shift / radix), exact quotient for any 17-bit dividend
   function automatic logic [17:0] recip(unit_idx_type idx, logic leap);
      logic [17:0] m;
      unique case (idx)
         UNIT_CENTI: m = 18'd167773;
         UNIT_SEC:   m = 18'd139811;
         UNIT_MIN:   m = 18'd139811;
         UNIT_HOUR:  m = 18'd174763;
         default:    m = leap ? 18'd182858 : 18'd183358;
      endcase
      return m;
   endfunction

   function automatic logic [4:0] recip_shift(unit_idx_type idx);
      logic [4:0] s;
      unique case (idx)
         UNIT_CENTI: s = 5'd24;
         UNIT_SEC:   s = 5'd23;
         UNIT_MIN:   s = 5'd23;
         UNIT_HOUR:  s = 5'd22;
         default:    s = 5'd26;
      endcase
      return s;
   endfunction

   function automatic logic [8:0] unit_of(tai_item_type it, unit_idx_type idx);
      logic [8:0] v;
      unique case (idx)
         UNIT_CENTI: v = {2'b00, it.centiseconds};
         UNIT_SEC:   v = {3'b000, it.seconds};
         UNIT_MIN:   v = {3'b000, it.minutes};
         UNIT_HOUR:  v = {4'b0000, it.hours};
         UNIT_DAY:   v = it.day_of_year;
         default:    v = '0;
      endcase
      return v;
   endfunction

   function automatic tai_item_type with_unit(tai_item_type it, unit_idx_type idx,
                                              logic [8:0] v);
      tai_item_type r;
      r = it;
      unique case (idx)
         UNIT_CENTI: r.centiseconds = v[6:0];
         UNIT_SEC:   r.seconds      = v[5:0];
         UNIT_MIN:   r.minutes      = v[5:0];
         UNIT_HOUR:  r.hours        = v[4:0];
         UNIT_DAY:   r.day_of_year  = v;
         default:    r = it;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/tai_quot_stage.sv @@
// quotient stage: divides the running unit sum by its radix through a reciprocal multiply
module tai_quot_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  tai_pkg::unit_idx_type unit_idx,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tai_pkg::tai_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tai_pkg::tai_item_type out_item
);

   logic                  valid_ff;
   logic                  valid_in;
   tai_pkg::tai_item_type item_ff;
   tai_pkg::tai_item_type item_in;
   logic                  leap;
   logic [34:0]           prod;

   assign leap = (in_item.year[1:0] == 2'b00);
   assign prod = 35'(in_item.sum) * 35'(tai_pkg::recip(unit_idx, leap));

   always_comb begin
      item_in       = in_item;
      item_in.quot  = 16'(prod >> tai_pkg::recip_shift(unit_idx));
      item_in.below = in_item.sum < 17'(tai_pkg::radix(unit_idx, leap));
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/tai_carry_stage.sv @@
// carry stage: settles one unit from its quotient and sets up the sum of the unit above
module tai_carry_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  tai_pkg::unit_idx_type unit_idx,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tai_pkg::tai_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tai_pkg::tai_item_type out_item
);

   logic                  valid_ff;
   logic                  valid_in;
   tai_pkg::tai_item_type item_ff;
   tai_pkg::tai_item_type item_in;
   logic                  leap;
   logic                  touched;
   logic [8:0]            rdx;
   logic [16:0]           rem;

   assign leap    = (in_item.year[1:0] == 2'b00);
   assign rdx     = tai_pkg::radix(unit_idx, leap);
   assign touched = in_item.live && (in_item.start <= unit_idx);
   assign rem     = in_item.sum - 17'(25'(in_item.quot) * 25'(rdx));

   always_comb begin
      item_in = in_item;
      if (touched) begin
         if (in_item.below) begin
            // ripple stops here, units above pass through
            item_in      = tai_pkg::with_unit(item_in, unit_idx, in_item.sum[8:0]);
            item_in.live = 1'b0;
         end else if (unit_idx == tai_pkg::UNIT_DAY) begin
            // day wraps past year end, counting from 1
            item_in      = tai_pkg::with_unit(item_in, unit_idx, 9'(rem) + 9'd1);
            item_in.year = in_item.year + 16'd1;
         end else begin
            item_in       = tai_pkg::with_unit(item_in, unit_idx, 9'(rem));
            item_in.carry = in_item.quot;
         end
      end
      if (unit_idx != tai_pkg::UNIT_DAY) begin
         item_in.sum = 17'(tai_pkg::unit_of(item_in, unit_idx + 3'd1)) + 17'(item_in.carry);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/time_array_increment_unit.sv @@
// top level of the time stamp increment pipeline
//
// Adds req_increment, in the unit picked by req_resolution (1 centisecond up to
// 5 day), to the time stamp on the req_ channel and returns the new stamp on
// the rsp_ channel. Both channels are valid/ready; a transaction moves on a
// rising edge with valid and ready both high. Resolution codes outside 1..5
// return the stamp unchanged.
// The work runs through 11 register stages: an entry stage that forms the
// first unit sum, then a quotient stage (reciprocal multiply) and a carry
// stage for each of the five units. A result passes through every one of these
// registers in order before it shows on rsp_, and one transaction per cycle is
// taken while rsp_ready does not stall the pipeline.
// Every stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stall on rsp_ready holds the result in place while
// empty stages behind it keep filling; req_ready falls only once the whole
// pipeline is full. Synchronous reset empties every stage; no result is lost
// or repeated across a stall.
module time_array_increment_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [6:0]  req_centiseconds,
   input  logic [5:0]  req_seconds,
   input  logic [5:0]  req_minutes,
   input  logic [4:0]  req_hours,
   input  logic [8:0]  req_day_of_year,
   input  logic [15:0] req_year,
   input  logic [15:0] req_increment,
   input  logic [2:0]  req_resolution,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_new_centiseconds,
   output logic [5:0]  rsp_new_seconds,
   output logic [5:0]  rsp_new_minutes,
   output logic [4:0]  rsp_new_hours,
   output logic [8:0]  rsp_new_day_of_year,
   output logic [15:0] rsp_new_year
);

   localparam int STAGES = 2 * tai_pkg::UNIT_COUNT + 1;

   logic [STAGES-1:0]     stg_valid;
   logic [STAGES-1:0]     stg_ready;
   tai_pkg::tai_item_type stg_item [STAGES];

   logic                  ent_valid_ff;
   logic                  ent_valid_in;
   tai_pkg::tai_item_type ent_item_ff;
   tai_pkg::tai_item_type ent_item_in;

   // entry stage: latch the stamp and form the centisecond sum
   always_comb begin
      ent_item_in.centiseconds = req_centiseconds;
      ent_item_in.seconds      = req_seconds;
      ent_item_in.minutes      = req_minutes;
      ent_item_in.hours        = req_hours;
      ent_item_in.day_of_year  = req_day_of_year;
      ent_item_in.year         = req_year;
      ent_item_in.carry        = req_increment;
      ent_item_in.sum          = 17'(req_centiseconds) + 17'(req_increment);
      ent_item_in.quot         = '0;
      ent_item_in.below        = 1'b0;
      ent_item_in.start        = req_resolution - tai_pkg::RES_CENTI;
      ent_item_in.live         = (req_resolution >= tai_pkg::RES_CENTI) &&
                                 (req_resolution <= tai_pkg::RES_DAY);
   end

   assign req_ready    = !ent_valid_ff || stg_ready[0];
   assign ent_valid_in = req_ready ? req_valid : ent_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ent_item_ff <= ent_item_in;
      end
   end

   assign stg_valid[0] = ent_valid_ff;
   assign stg_item[0]  = ent_item_ff;

   for (genvar i = 0; i < tai_pkg::UNIT_COUNT; i++) begin : g_unit
      tai_quot_stage u_quot (
         .clock     (clock),
         .reset     (reset),
         .unit_idx  (3'(i)),
         .in_valid  (stg_valid[2*i]),
         .in_ready  (stg_ready[2*i]),
         .in_item   (stg_item[2*i]),
         .out_valid (stg_valid[2*i+1]),
         .out_ready (stg_ready[2*i+1]),
         .out_item  (stg_item[2*i+1])
      );

      tai_carry_stage u_carry (
         .clock     (clock),
         .reset     (reset),
         .unit_idx  (3'(i)),
         .in_valid  (stg_valid[2*i+1]),
         .in_ready  (stg_ready[2*i+1]),
         .in_item   (stg_item[2*i+1]),
         .out_valid (stg_valid[2*i+2]),
         .out_ready (stg_ready[2*i+2]),
         .out_item  (stg_item[2*i+2])
      );
   end

   assign stg_ready[STAGES-1] = rsp_ready;
   assign rsp_valid           = stg_valid[STAGES-1];

   assign rsp_new_centiseconds = stg_item[STAGES-1].centiseconds;
   assign rsp_new_seconds      = stg_item[STAGES-1].seconds;
   assign rsp_new_minutes      = stg_item[STAGES-1].minutes;
   assign rsp_new_hours        = stg_item[STAGES-1].hours;
   assign rsp_new_day_of_year  = stg_item[STAGES-1].day_of_year;
   assign rsp_new_year         = stg_item[STAGES-1].year;

endmodule

@@ hw/rtl/tai_checker.sv @@
// port checks for the time stamp increment pipeline, bound to the top level
`include "time_array_increment_unit_defines.svh"

module tai_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_new_centiseconds,
   input logic [5:0]  rsp_new_seconds,
   input logic [5:0]  rsp_new_minutes,
   input logic [4:0]  rsp_new_hours,
   input logic [8:0]  rsp_new_day_of_year,
   input logic [15:0] rsp_new_year
);

   logic [48:0] rsp_payload;

   assign rsp_payload = {rsp_new_centiseconds, rsp_new_seconds, rsp_new_minutes,
                         rsp_new_hours, rsp_new_day_of_year, rsp_new_year};

   // reset empties the pipeline
   `TAI_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_valid, "result valid after reset")

   // a free-running receiver never backs up into the request side
   `TAI_ASSERT(a_ready_when_drained, rsp_ready |-> req_ready, "req_ready low with rsp_ready")

   `TAI_ASSERT(a_rsp_valid_holds, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped in stall")

   `TAI_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "result changed")

endmodule

bind time_array_increment_unit tai_checker u_tai_checker (.*);
